@@ sv/npcs_pkg.sv @@
// Package for the nearest palette colour search block.
// Holds the action codes, register indexes, state and tag types and fixed constants.
// Depends on nothing; every other file of the block refers to it by scoped names.
package npcs_pkg;

    // Action carried by an input beat.
    typedef enum logic [1:0] {
        ACT_WRITE_COLOR = 2'd0,
        ACT_WRITE_FLAG  = 2'd1,
        ACT_QUERY       = 2'd2
    } action_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENTRY_COUNT  = 2'd0;
    localparam logic [1:0] CFG_USE_BEDROCK  = 2'd1;
    localparam logic [1:0] CFG_FLAT_ONLY    = 2'd2;
    localparam logic [1:0] CFG_COLOR_FILTER = 2'd3;

    // Colour filter codes. The unused code behaves as no filter.
    localparam logic [1:0] FILTER_GRAY  = 2'd1;
    localparam logic [1:0] FILTER_FIXED = 2'd2;

    // The two entries kept by the fixed filter (black and white).
    localparam int FIXED_ENTRY_A = 7;
    localparam int FIXED_ENTRY_B = 28;

    // Field widths of the beats.
    localparam int COLOR_W  = 24;
    localparam int CODE_W   = 8;
    localparam int CFG_W    = 7;

    // Redmean distance scaled by 512: (1024+s)*dr^2 + 2048*dg^2 + (1534-s)*db^2.
    localparam int SQ_W     = 16;
    localparam int WEIGHT_W = 11;
    localparam int PROD_W   = 27;
    localparam int DIST_W   = 29;
    localparam logic [WEIGHT_W-1:0] RED_BASE  = 11'd1024;
    localparam logic [WEIGHT_W-1:0] BLUE_BASE = 11'd1534;
    localparam int GREEN_SHIFT = 11;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Tag that travels with each candidate through the distance pipeline.
    typedef struct packed {
        logic              valid;
        logic              qual;
        logic              gray_chk;
        logic [CODE_W-1:0] code;
    } cand_tag_t;

endpackage

@@ sv/npcs_palette_ram.sv @@
// Palette colour memory: one write port and two registered read ports.
// Depends on npcs_pkg for the word width.
module npcs_palette_ram #(
    parameter int ADDR_W = 9
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [npcs_pkg::COLOR_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]            rd_addr_a,
    input  logic [ADDR_W-1:0]            rd_addr_b,
    output logic [npcs_pkg::COLOR_W-1:0] rd_data_a,
    output logic [npcs_pkg::COLOR_W-1:0] rd_data_b
);

    logic [npcs_pkg::COLOR_W-1:0] mem_reg [2**ADDR_W];
    logic [npcs_pkg::COLOR_W-1:0] rd_a_reg;
    logic [npcs_pkg::COLOR_W-1:0] rd_b_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge aclk) begin
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ sv/npcs_dist_pipe.sv @@
// Redmean distance pipeline: squares, weighting, then the sum, one register each.
// Depends on npcs_pkg for widths, weights and the candidate tag type.
module npcs_dist_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [7:0]                   pix_red,
    input  logic [7:0]                   pix_green,
    input  logic [7:0]                   pix_blue,
    input  logic [npcs_pkg::COLOR_W-1:0] cand_word,
    input  logic [npcs_pkg::COLOR_W-1:0] gray_word,
    input  npcs_pkg::cand_tag_t          tag_in,
    output npcs_pkg::cand_tag_t          tag_out,
    output logic [npcs_pkg::DIST_W-1:0]  cand_dist,
    output logic                         busy
);

    logic [7:0] cand_r, cand_g, cand_b;
    logic [7:0] diff_r, diff_g, diff_b;
    logic       gray_ok;

    npcs_pkg::cand_tag_t tag2_reg, tag3_reg, tag4_reg;
    npcs_pkg::cand_tag_t tag2_next;

    logic [npcs_pkg::SQ_W-1:0]     sq_r_reg, sq_g_reg, sq_b_reg;
    logic [8:0]                    sum_reg;
    logic [npcs_pkg::WEIGHT_W-1:0] weight_r, weight_b;
    logic [npcs_pkg::PROD_W-1:0]   prod_r_reg, prod_g_reg, prod_b_reg;
    logic [npcs_pkg::DIST_W-1:0]   dist_reg;

    // Channel differences and the gray test on the second-edition shade-0 word.
    always_comb begin
        cand_r  = cand_word[23:16];
        cand_g  = cand_word[15:8];
        cand_b  = cand_word[7:0];
        diff_r  = (pix_red   > cand_r) ? pix_red   - cand_r : cand_r - pix_red;
        diff_g  = (pix_green > cand_g) ? pix_green - cand_g : cand_g - pix_green;
        diff_b  = (pix_blue  > cand_b) ? pix_blue  - cand_b : cand_b - pix_blue;
        gray_ok = (gray_word[23:16] == gray_word[15:8]) && (gray_word[15:8] == gray_word[7:0]);
        tag2_next      = tag_in;
        tag2_next.qual = tag_in.qual && (!tag_in.gray_chk || gray_ok);
    end

    // Weights depend on the red sum.
    assign weight_r = npcs_pkg::RED_BASE  + {2'b00, sum_reg};
    assign weight_b = npcs_pkg::BLUE_BASE - {2'b00, sum_reg};

    // Tag valid bits through the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag2_reg <= tag2_next;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    // Data path: squares, then weighted products, then the total.
    always_ff @(posedge aclk) begin
        sq_r_reg   <= npcs_pkg::SQ_W'(diff_r) * npcs_pkg::SQ_W'(diff_r);
        sq_g_reg   <= npcs_pkg::SQ_W'(diff_g) * npcs_pkg::SQ_W'(diff_g);
        sq_b_reg   <= npcs_pkg::SQ_W'(diff_b) * npcs_pkg::SQ_W'(diff_b);
        sum_reg    <= {1'b0, pix_red} + {1'b0, cand_r};
        prod_r_reg <= npcs_pkg::PROD_W'(weight_r) * npcs_pkg::PROD_W'(sq_r_reg);
        prod_b_reg <= npcs_pkg::PROD_W'(weight_b) * npcs_pkg::PROD_W'(sq_b_reg);
        prod_g_reg <= npcs_pkg::PROD_W'(sq_g_reg) << npcs_pkg::GREEN_SHIFT;
        dist_reg   <= npcs_pkg::DIST_W'(prod_r_reg) + npcs_pkg::DIST_W'(prod_g_reg)
                    + npcs_pkg::DIST_W'(prod_b_reg);
    end

    assign tag_out   = tag4_reg;
    assign cand_dist = dist_reg;
    assign busy      = tag2_reg.valid || tag3_reg.valid || tag4_reg.valid;

endmodule

@@ sv/nearest_palette_color_search_top.sv @@
// Top level of the nearest palette colour search block.
// Depends on npcs_pkg, npcs_palette_ram and npcs_dist_pipe.
//
// Colour and flag writes leave the input ready again at once. A query scans
// entries 0 to entry_count-1 (capped at MAX_ENTRIES) and every shade of each, one
// palette word per cycle from the memory's candidate read port, so the input stays
// stalled after the query beat through the scan itself, the memory read register,
// three distance stages, the check that the pipeline is empty and the result load.
// An entry count of zero goes straight to the result load, with the input stalled
// until it is done. Skipped candidates still take their scan slot. The result beat
// sits in an output register, so the next beat can be accepted while it waits; a
// later query holds its result load until that beat has been taken. Palette words
// start undefined and carry no valid bits; availability flags clear at reset.
module nearest_palette_color_search_top #(
    parameter int MAX_ENTRIES = 64,
    parameter int SHADES      = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [5:0]                 s_entry_index,
    input  logic [1:0]                 s_shade_index,
    input  logic                       s_edition,
    input  logic [7:0]                 s_red_value,
    input  logic [7:0]                 s_green_value,
    input  logic [7:0]                 s_blue_value,
    input  logic                       s_available_flag,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_best_code,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [npcs_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int EW     = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int SW     = (SHADES > 1) ? $clog2(SHADES) : 1;
    localparam int AW     = 1 + EW + SW;
    localparam int MID    = SHADES / 2;

    npcs_pkg::state_t state_reg, state_next;

    logic [npcs_pkg::CFG_W-1:0] entry_count_reg;
    logic                       use_bedrock_reg;
    logic                       flat_only_reg;
    logic [1:0]                 color_filter_reg;

    logic [MAX_ENTRIES-1:0]        avail_reg;
    logic [EW-1:0]                 entry_reg;
    logic [SW-1:0]                 shade_reg;
    logic [npcs_pkg::CODE_W-1:0]   code_reg;
    logic [7:0]                    pix_r_reg, pix_g_reg, pix_b_reg;
    npcs_pkg::cand_tag_t           tag1_reg, tag_issue, tag_done;
    logic                          found_reg;
    logic [npcs_pkg::DIST_W-1:0]   best_reg;
    logic [npcs_pkg::CODE_W-1:0]   best_code_reg;
    logic                          m_valid_reg;
    logic [7:0]                    m_code_reg;

    logic                          accept, wr_color, wr_flag, start_query;
    logic                          issue, last_issue, load_out, pipe_busy, take_cand;
    logic                          dist_busy;
    logic [CW-1:0]                 search_n;
    logic                          entry_ok, shade_ok, filter_ok;
    logic [AW-1:0]                 wr_addr, rd_addr_a, rd_addr_b;
    logic [npcs_pkg::COLOR_W-1:0]  cand_word, gray_word;
    logic [npcs_pkg::DIST_W-1:0]   cand_dist;

    // Beat decode.
    assign accept      = s_valid && s_ready;
    assign entry_ok    = 32'(s_entry_index) < MAX_ENTRIES;
    assign shade_ok    = 32'(s_shade_index) < SHADES;
    assign wr_color    = accept && (s_action == npcs_pkg::ACT_WRITE_COLOR) && entry_ok
                         && shade_ok;
    assign wr_flag     = accept && (s_action == npcs_pkg::ACT_WRITE_FLAG) && entry_ok;
    assign start_query = accept && (s_action == npcs_pkg::ACT_QUERY);

    // Number of entries searched, capped at the palette size.
    assign search_n   = (32'(entry_count_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                              : CW'(entry_count_reg);
    assign last_issue = (CW'(entry_reg) == search_n - CW'(1))
                        && (32'(shade_reg) == SHADES - 1);
    assign pipe_busy  = tag1_reg.valid || tag_done.valid || dist_busy;

    // Sequencer: next state and control strobes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            npcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (start_query) begin
                    state_next = (search_n == '0) ? npcs_pkg::ST_FINISH : npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN: begin
                issue = 1'b1;
                if (last_issue) begin
                    state_next = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = npcs_pkg::ST_FINISH;
                end
            end
            npcs_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            default: state_next = npcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= npcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg  <= npcs_pkg::CFG_W'(64);
            use_bedrock_reg  <= 1'b0;
            flat_only_reg    <= 1'b0;
            color_filter_reg <= 2'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                npcs_pkg::CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_wdata;
                npcs_pkg::CFG_USE_BEDROCK:  use_bedrock_reg  <= cfg_wdata[0];
                npcs_pkg::CFG_FLAT_ONLY:    flat_only_reg    <= cfg_wdata[0];
                npcs_pkg::CFG_COLOR_FILTER: color_filter_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Availability flags, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avail_reg <= '0;
        end else if (wr_flag) begin
            avail_reg[EW'(s_entry_index)] <= s_available_flag;
        end
    end

    // Scan counters; the code counter follows entry*SHADES+shade modulo 256.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            shade_reg <= '0;
            code_reg  <= '0;
        end else if (start_query) begin
            entry_reg <= '0;
            shade_reg <= '0;
            code_reg  <= '0;
        end else if (issue) begin
            code_reg <= code_reg + npcs_pkg::CODE_W'(1);
            if (32'(shade_reg) == SHADES - 1) begin
                shade_reg <= '0;
                entry_reg <= entry_reg + EW'(1);
            end else begin
                shade_reg <= shade_reg + SW'(1);
            end
        end
    end

    // Pixel held for the whole query.
    always_ff @(posedge aclk) begin
        if (start_query) begin
            pix_r_reg <= s_red_value;
            pix_g_reg <= s_green_value;
            pix_b_reg <= s_blue_value;
        end
    end

    // Filters known before the read: fixed entries, availability and middle shade.
    assign filter_ok = (color_filter_reg != npcs_pkg::FILTER_FIXED)
                       || (32'(entry_reg) == npcs_pkg::FIXED_ENTRY_A)
                       || (32'(entry_reg) == npcs_pkg::FIXED_ENTRY_B);

    always_comb begin
        tag_issue.valid    = issue;
        tag_issue.qual     = filter_ok && (!use_bedrock_reg || avail_reg[entry_reg])
                             && (!flat_only_reg || (32'(shade_reg) == MID));
        tag_issue.gray_chk = (color_filter_reg == npcs_pkg::FILTER_GRAY);
        tag_issue.code     = code_reg;
    end

    // Tag aligned with the registered memory read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
        end else begin
            tag1_reg <= tag_issue;
        end
    end

    // Memory addresses: {edition, entry, shade}. Writes happen only while idle,
    // so they never meet the reads of a scan.
    assign wr_addr   = {s_edition, EW'(s_entry_index), SW'(s_shade_index)};
    assign rd_addr_a = {use_bedrock_reg, entry_reg, shade_reg};
    assign rd_addr_b = {1'b1, entry_reg, SW'(0)};

    npcs_palette_ram #(
        .ADDR_W(AW)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_color),
        .wr_addr   (wr_addr),
        .wr_data   ({s_red_value, s_green_value, s_blue_value}),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (cand_word),
        .rd_data_b (gray_word)
    );

    npcs_dist_pipe u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_red   (pix_r_reg),
        .pix_green (pix_g_reg),
        .pix_blue  (pix_b_reg),
        .cand_word (cand_word),
        .gray_word (gray_word),
        .tag_in    (tag1_reg),
        .tag_out   (tag_done),
        .cand_dist (cand_dist),
        .busy      (dist_busy)
    );

    // Running minimum; a tie keeps the earlier candidate.
    assign take_cand = tag_done.valid && tag_done.qual
                       && (!found_reg || (cand_dist < best_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (start_query) begin
            found_reg <= 1'b0;
        end else if (take_cand) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_cand) begin
            best_reg      <= cand_dist;
            best_code_reg <= tag_done.code;
        end
    end

    // Output register for the result beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_code_reg <= found_reg ? best_code_reg : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_best_code = m_code_reg;

endmodule

@@ sv/npcs_checker.sv @@
// Port-level checker for the nearest palette colour search block, with its bind.
// Depends on npcs_pkg for the action codes; attaches to nearest_palette_color_search_top.
module npcs_checker #(
    parameter int MAX_ENTRIES = 64,
    parameter int SHADES      = 3
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_action,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_best_code
);

    // A result beat that is not taken stays, with its code unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_code))
        else $error("result beat dropped or changed while stalled");

    // Nothing is accepted in the cycle right after a query beat: the scan owns the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == npcs_pkg::ACT_QUERY) |=> !s_ready)
        else $error("input accepted while a query is being searched");

    // A returned code names an existing candidate when codes fit in eight bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_best_code) < MAX_ENTRIES * SHADES) || (MAX_ENTRIES * SHADES > 256))
        else $error("best code beyond the palette");

    // A new result beat appears only after a query has been accepted earlier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready || !$past(s_ready))
        else $error("result beat without a search");

endmodule

bind nearest_palette_color_search_top npcs_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .SHADES     (SHADES)
) u_npcs_checker (.*);

@@ tb/nearest_palette_color_search_top_tb.sv @@
// Self-checking testbench for the nearest palette colour search block.
// Depends on npcs_pkg and nearest_palette_color_search_top; predicts every query result
// from its own copy of the palette, the availability flags and the register settings.
module nearest_palette_color_search_top_tb;

    localparam int MAX_ENTRIES    = 64;
    localparam int SHADES         = 3;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 12;
    localparam int SEGMENT_BEATS  = 75;
    localparam int HOLD_SEGMENT   = 5;
    localparam int PAUSE_SEGMENT  = 9;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] ACT_NONE           = 2'd3;
    localparam logic [1:0] OUT_OF_RANGE_SHADE = 2'd3;
    localparam logic [1:0] FILTER_ALL         = 2'd0;
    localparam logic [1:0] FILTER_SPARE       = 2'd3;

    // Redmean weights, scaled by 512.
    localparam int unsigned RED_WEIGHT   = 1024;
    localparam int unsigned GREEN_WEIGHT = 2048;
    localparam int unsigned BLUE_WEIGHT  = 1534;

    typedef struct {
        logic [1:0] action;
        logic [5:0] entry;
        logic [1:0] shade;
        logic       edition;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flag;
    } palette_beat_t;

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [1:0] s_action         = npcs_pkg::ACT_WRITE_COLOR;
    logic [5:0] s_entry_index    = 6'd0;
    logic [1:0] s_shade_index    = 2'd0;
    logic       s_edition        = 1'b0;
    logic [7:0] s_red_value      = 8'd0;
    logic [7:0] s_green_value    = 8'd0;
    logic [7:0] s_blue_value     = 8'd0;
    logic       s_available_flag = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_best_code;
    logic       cfg_wr_en        = 1'b0;
    logic [1:0] cfg_index        = npcs_pkg::CFG_ENTRY_COUNT;
    logic [npcs_pkg::CFG_W-1:0] cfg_wdata = '0;

    // Mirror of the block's state and registers.
    logic [23:0] palette_mem [2][MAX_ENTRIES][SHADES];
    bit          bedrock_avail [MAX_ENTRIES];
    logic [6:0]  span_setting = 7'd64;
    logic        bedrock_mode = 1'b0;
    logic        flat_mode    = 1'b0;
    logic [1:0]  filter_mode  = FILTER_ALL;

    palette_beat_t beat_queue [$];
    logic [7:0]    expected_codes [$];
    palette_beat_t next_beat;

    int send_idle_pct  = 18;
    int recv_stall_pct = 53;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int error_count     = 0;
    int results_checked = 0;
    int color_writes    = 0;
    int flag_writes     = 0;
    int ignored_beats   = 0;
    int settings_loaded = 0;

    logic       result_seen = 1'b0;
    logic [7:0] result_code = 8'd0;
    logic [7:0] wanted_code;

    nearest_palette_color_search_top #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SHADES      (SHADES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_entry_index    (s_entry_index),
        .s_shade_index    (s_shade_index),
        .s_edition        (s_edition),
        .s_red_value      (s_red_value),
        .s_green_value    (s_green_value),
        .s_blue_value     (s_blue_value),
        .s_available_flag (s_available_flag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_best_code      (m_best_code),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Closest candidate under the redmean distance; ties keep the earliest in scan order.
    function automatic logic [7:0] nearest_code(logic [7:0] pr, logic [7:0] pg,
                                                logic [7:0] pb);
        int unsigned span, best_dist, cand_dist, rsum, dr, dg, db, code;
        bit          found;
        logic [23:0] word;
        span = (span_setting > MAX_ENTRIES) ? MAX_ENTRIES : span_setting;
        found = 1'b0;
        best_dist = 0;
        code = 0;
        for (int e = 0; e < span; e++) begin
            if (filter_mode == npcs_pkg::FILTER_GRAY) begin
                // The gray test always looks at the second-edition first shade.
                word = palette_mem[1][e][0];
                if (word[23:16] != word[15:8] || word[15:8] != word[7:0]) continue;
            end else if (filter_mode == npcs_pkg::FILTER_FIXED) begin
                if (e != npcs_pkg::FIXED_ENTRY_A && e != npcs_pkg::FIXED_ENTRY_B) continue;
            end
            if (bedrock_mode && !bedrock_avail[e]) continue;
            for (int sh = 0; sh < SHADES; sh++) begin
                if (flat_mode && sh != SHADES / 2) continue;
                word = palette_mem[bedrock_mode][e][sh];
                rsum = 32'(pr) + 32'(word[23:16]);
                dr = (pr > word[23:16]) ? 32'(pr - word[23:16]) : 32'(word[23:16] - pr);
                dg = (pg > word[15:8]) ? 32'(pg - word[15:8]) : 32'(word[15:8] - pg);
                db = (pb > word[7:0]) ? 32'(pb - word[7:0]) : 32'(word[7:0] - pb);
                cand_dist = (RED_WEIGHT + rsum) * dr * dr + GREEN_WEIGHT * dg * dg
                          + (BLUE_WEIGHT - rsum) * db * db;
                if (!found || cand_dist < best_dist) begin
                    found = 1'b1;
                    best_dist = cand_dist;
                    code = e * SHADES + sh;
                end
            end
        end
        return found ? 8'(code) : 8'd0;
    endfunction

    function automatic logic [23:0] pick_color();
        int unsigned mode;
        logic [7:0]  level;
        mode = $urandom_range(9);
        level = 8'($urandom_range(255));
        if (mode == 0) return 24'h000000;
        if (mode == 1) return 24'hFFFFFF;
        if (mode <= 4) return {level, level, level};
        return 24'($urandom);
    endfunction

    // Pixels are mostly near a stored colour, so close races between candidates occur.
    function automatic logic [23:0] pick_pixel();
        int unsigned mode;
        mode = $urandom_range(9);
        if (mode <= 3)
            return palette_mem[$urandom_range(1)][$urandom_range(MAX_ENTRIES - 1)]
                              [$urandom_range(SHADES - 1)] ^ (24'($urandom) & 24'h030303);
        if (mode <= 5) return pick_color();
        return 24'($urandom);
    endfunction

    // Fields that a beat does not use still carry random values.
    function automatic palette_beat_t random_beat();
        palette_beat_t beat;
        beat.action  = 2'($urandom_range(3));
        beat.entry   = 6'($urandom_range(63));
        beat.shade   = 2'($urandom_range(3));
        beat.edition = 1'($urandom_range(1));
        beat.red     = 8'($urandom_range(255));
        beat.green   = 8'($urandom_range(255));
        beat.blue    = 8'($urandom_range(255));
        beat.flag    = 1'($urandom_range(1));
        return beat;
    endfunction

    function automatic void push_query(logic [23:0] rgb);
        palette_beat_t beat;
        beat = random_beat();
        beat.action = npcs_pkg::ACT_QUERY;
        {beat.red, beat.green, beat.blue} = rgb;
        beat_queue.push_back(beat);
    endfunction

    function automatic void push_color(logic [5:0] entry, logic [1:0] shade, logic edition,
                                       logic [23:0] rgb);
        palette_beat_t beat;
        beat = random_beat();
        beat.action = npcs_pkg::ACT_WRITE_COLOR;
        beat.entry = entry;
        beat.shade = shade;
        beat.edition = edition;
        {beat.red, beat.green, beat.blue} = rgb;
        beat_queue.push_back(beat);
    endfunction

    function automatic void push_flag(logic [5:0] entry, logic flag);
        palette_beat_t beat;
        beat = random_beat();
        beat.action = npcs_pkg::ACT_WRITE_FLAG;
        beat.entry = entry;
        beat.flag = flag;
        beat_queue.push_back(beat);
    endfunction

    function automatic void push_noise();
        palette_beat_t beat;
        beat = random_beat();
        beat.action = ACT_NONE;
        beat_queue.push_back(beat);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Stimulus steps just after the rising edge, clear of the driver and the checker.
    task automatic next_cycle();
        @(posedge aclk);
        #1;
    endtask

    task automatic await_results();
        do next_cycle();
        while (beat_queue.size() != 0 || s_valid || expected_codes.size() != 0);
    endtask

    // Registers are only written once the block has finished all its work.
    task automatic load_settings(input logic [6:0] count, input logic bedrock,
                                 input logic flat, input logic [1:0] filter);
        await_results();
        repeat (DRAIN_CYCLES) next_cycle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= npcs_pkg::CFG_ENTRY_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_index <= npcs_pkg::CFG_USE_BEDROCK;
        cfg_wdata <= {6'd0, bedrock};
        @(posedge aclk);
        cfg_index <= npcs_pkg::CFG_FLAT_ONLY;
        cfg_wdata <= {6'd0, flat};
        @(posedge aclk);
        cfg_index <= npcs_pkg::CFG_COLOR_FILTER;
        cfg_wdata <= {5'd0, filter};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        span_setting = count;
        bedrock_mode = bedrock;
        flat_mode = flat;
        filter_mode = filter;
        settings_loaded++;
        #1;
    endtask

    // Driver: updates the mirror on every accepted beat, then offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                case (s_action)
                    npcs_pkg::ACT_WRITE_COLOR: begin
                        if (s_shade_index < SHADES) begin
                            palette_mem[s_edition][s_entry_index][s_shade_index] =
                                {s_red_value, s_green_value, s_blue_value};
                            color_writes++;
                        end else begin
                            ignored_beats++;
                        end
                    end
                    npcs_pkg::ACT_WRITE_FLAG: begin
                        bedrock_avail[s_entry_index] = s_available_flag;
                        flag_writes++;
                    end
                    npcs_pkg::ACT_QUERY: begin
                        expected_codes.push_back(
                            nearest_code(s_red_value, s_green_value, s_blue_value));
                    end
                    default: begin
                        ignored_beats++;
                    end
                endcase
            end
            if (!s_valid || s_ready) begin
                if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = beat_queue.pop_front();
                    s_valid          <= 1'b1;
                    s_action         <= next_beat.action;
                    s_entry_index    <= next_beat.entry;
                    s_shade_index    <= next_beat.shade;
                    s_edition        <= next_beat.edition;
                    s_red_value      <= next_beat.red;
                    s_green_value    <= next_beat.green;
                    s_blue_value     <= next_beat.blue;
                    s_available_flag <= next_beat.flag;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: capture each result beat at the rising edge, compare it at the falling edge.
    always @(posedge aclk) begin
        result_seen <= aresetn && m_valid && m_ready;
        result_code <= m_best_code;
    end

    always @(negedge aclk) begin
        if (result_seen) begin
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("best_code %0d with no query outstanding",
                                          result_code));
            end else begin
                wanted_code = expected_codes.pop_front();
                if (result_code !== wanted_code)
                    report_mismatch($sformatf("best_code %0d, expected %0d",
                                              result_code, wanted_code));
                results_checked++;
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          pick;
        logic [1:0]  shade;
        logic        edition;
        logic [23:0] colour;
        logic [6:0]  count;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        next_cycle();

        // Fill every palette word before any query; black and white sit at the fixed entries.
        for (int e = 0; e < MAX_ENTRIES; e++) begin
            for (int sh = 0; sh < SHADES; sh++) begin
                for (int ed = 0; ed < 2; ed++) begin
                    if (e == npcs_pkg::FIXED_ENTRY_A) colour = 24'h000000;
                    else if (e == npcs_pkg::FIXED_ENTRY_B) colour = 24'hFFFFFF;
                    else if (ed == 1 && sh == 0 && $urandom_range(2) == 0)
                        colour = {3{8'($urandom_range(255))}};
                    else colour = pick_color();
                    push_color(6'(e), 2'(sh), 1'(ed), colour);
                end
            end
        end
        for (int e = 0; e < MAX_ENTRIES; e++)
            push_flag(6'(e),
                      (e == npcs_pkg::FIXED_ENTRY_A || e == npcs_pkg::FIXED_ENTRY_B)
                          ? 1'b1 : 1'($urandom_range(1)));

        // Reset settings: black, white, a tie, a write to a missing shade, an unknown action.
        push_query(24'h000000);
        push_query(24'hFFFFFF);
        push_color(6'd5, 2'd2, 1'b0, 24'h123456);
        push_color(6'd50, 2'd1, 1'b0, 24'h123456);
        push_query(24'h123456);
        push_color(6'd9, OUT_OF_RANGE_SHADE, 1'b0, 24'hABCDEF);
        push_query(24'hABCDEF);
        push_noise();
        push_query(24'h808080);

        // An entry count of zero searches nothing.
        load_settings(7'd0, 1'b0, 1'b0, FILTER_ALL);
        push_query(24'h3C5A78);

        // Oversized entry count, the spare filter code and the middle shade only.
        load_settings(7'd127, 1'b0, 1'b1, FILTER_SPARE);
        push_query(24'h000000);
        push_query(24'hC0FFEE);

        // Gray entries, first then second edition; white is withdrawn for one query.
        load_settings(7'd64, 1'b0, 1'b0, npcs_pkg::FILTER_GRAY);
        push_query(24'h7F7F7F);
        push_query(24'hFF0000);
        load_settings(7'd64, 1'b1, 1'b0, npcs_pkg::FILTER_GRAY);
        push_flag(6'(npcs_pkg::FIXED_ENTRY_B), 1'b0);
        push_query(24'hFFFFFF);
        push_flag(6'(npcs_pkg::FIXED_ENTRY_B), 1'b1);

        // Black and white entries only.
        load_settings(7'd64, 1'b0, 1'b1, npcs_pkg::FILTER_FIXED);
        push_query(24'h606060);
        push_query(24'hA0A0A0);

        // A single entry whose availability is switched on and off.
        load_settings(7'd1, 1'b1, 1'b0, FILTER_ALL);
        push_flag(6'd0, 1'b1);
        push_query(pick_pixel());
        push_flag(6'd0, 1'b0);
        push_query(pick_pixel());

        // Random segments, each under fresh register settings and an idling profile.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 53;
                recv_stall_pct = 18;
            end else if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            case ($urandom_range(7))
                0: count = 7'd0;
                1: count = 7'd1;
                2: count = 7'd64;
                3: count = 7'($urandom_range(65, 127));
                4, 5: count = 7'($urandom_range(1, 16));
                default: count = 7'($urandom_range(1, 64));
            endcase
            if (seg == HOLD_SEGMENT) count = 7'd3;
            load_settings(count, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          2'($urandom_range(3)));

            // Short queries against a stalled receiver fill the block and block its input.
            if (seg == HOLD_SEGMENT) begin
                hold_requests++;
                repeat (12) push_query(pick_pixel());
            end

            for (int k = 0; k < SEGMENT_BEATS; k++) begin
                if (seg == PAUSE_SEGMENT && k == SEGMENT_BEATS / 2) await_results();
                pick = $urandom_range(99);
                if (pick < 45) begin
                    push_query(pick_pixel());
                end else if (pick < 85) begin
                    shade = ($urandom_range(15) == 0) ? OUT_OF_RANGE_SHADE
                                                      : 2'($urandom_range(SHADES - 1));
                    edition = 1'($urandom_range(1));
                    colour = pick_color();
                    if (edition && shade == 2'd0 && $urandom_range(1) == 1)
                        colour = {3{colour[7:0]}};
                    push_color(6'($urandom_range(63)), shade, edition, colour);
                end else if (pick < 96) begin
                    push_flag(6'($urandom_range(63)), 1'($urandom_range(1)));
                end else begin
                    push_noise();
                end
            end
        end

        await_results();
        repeat (DRAIN_CYCLES) next_cycle();

        $display("Checked %0d query results after %0d colour writes, %0d flag writes and %0d %s",
                 results_checked, color_writes, flag_writes, ignored_beats, "ignored beats.");
        $display("Ran %0d register settings, including empty, single and oversized searches.",
                 settings_loaded);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
